[rtl/hhx_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and constants of the HTTP Host header extractor.
package hhx_pkg;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        logic       item_kind;
        logic [7:0] host_byte;
        logic [2:0] parse_status;
        logic       is_final;
    } t_out_item;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_GOT_CR  = 3'd1,
        PH_KEYWORD = 3'd2,
        PH_SKIP    = 3'd3,
        PH_VALUE   = 3'd4,
        PH_DONE    = 3'd5
    } t_phase;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NOT_HTTP  = 3'd1;
    localparam logic [2:0] ST_NO_HOST   = 3'd2;
    localparam logic [2:0] ST_EARLY_END = 3'd3;
    localparam logic [2:0] ST_TRUNCATED = 3'd4;

    localparam logic KIND_BYTE   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    // "HTTP/1." as it sits in bits 63:8 of the byte window
    localparam logic [55:0] HTTP_TAG = 56'h485454502F312E;
    localparam logic [3:0]  FLC_MAX  = 4'd15;
    localparam logic [3:0]  FLC_MIN  = 4'd8;
    localparam logic [2:0]  KEY_LEN  = 3'd5;

    localparam int QDEPTH = 4;
    localparam int QIDX_W = 2;
    localparam int QCNT_W = 3;

    function automatic logic [7:0] key_char(input logic [2:0] idx);
        logic [7:0] c;
        unique case (idx)
            3'd0:    c = 8'h48; // H
            3'd1:    c = 8'h6F; // o
            3'd2:    c = 8'h73; // s
            3'd3:    c = 8'h74; // t
            3'd4:    c = 8'h3A; // :
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

[rtl/hhx_front.sv]
`timescale 1ns / 1ps
// Front end: per-byte request parser that classifies each byte and emits result records.
module hhx_front #(
    parameter int HOST_MAX = 255
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_space,
    output logic              o_ready,
    input  hhx_pkg::t_in_item i_item,
    output logic              o_push,
    output hhx_pkg::t_out_item o_item
);
    import hhx_pkg::*;

    localparam int HL_W = $clog2(HOST_MAX + 2);
    localparam logic [HL_W-1:0] HL_MAX   = HL_W'(HOST_MAX);
    localparam logic [HL_W-1:0] HL_TRUNC = HL_W'(HOST_MAX + 1);

    t_phase          r_phase, n_phase, w_phase_step;
    logic [63:0]     r_recent, n_recent;
    logic [3:0]      r_flc, n_flc;
    logic [2:0]      r_kmc, n_kmc;
    logic [HL_W-1:0] r_hlen, n_hlen;

    logic       w_acc;
    logic [7:0] w_b;
    logic       w_eob;
    logic       w_emit_byte, w_emit_status;
    logic [2:0] w_status;

    assign o_ready = i_space;
    assign w_acc   = i_valid && i_space;
    assign w_b     = i_item.payload_byte;
    assign w_eob   = i_item.end_of_buffer;

    // next state
    always_comb begin
        w_phase_step = r_phase;
        n_recent     = r_recent;
        n_flc        = r_flc;
        n_kmc        = r_kmc;
        n_hlen       = r_hlen;
        unique case (r_phase)
            PH_FIRST: begin
                if (w_b == CH_CR) begin
                    if (r_flc >= FLC_MIN && r_recent[63:8] == HTTP_TAG) begin
                        w_phase_step = PH_GOT_CR;
                    end else begin
                        w_phase_step = PH_DONE;
                    end
                end else begin
                    n_recent = {r_recent[55:0], w_b};
                    if (r_flc < FLC_MAX) begin
                        n_flc = r_flc + 4'd1;
                    end
                end
            end
            PH_GOT_CR: begin
                if (w_b == CH_LF) begin
                    n_kmc        = '0;
                    w_phase_step = PH_KEYWORD;
                end else if (w_b != CH_CR) begin
                    w_phase_step = PH_SKIP;
                end
            end
            PH_KEYWORD: begin
                if (r_kmc == 3'd0 && w_b == CH_CR) begin
                    w_phase_step = PH_DONE;
                end else if (r_kmc < KEY_LEN && w_b == key_char(r_kmc)) begin
                    n_kmc = r_kmc + 3'd1;
                    if (r_kmc + 3'd1 == KEY_LEN) begin
                        n_hlen       = '0;
                        w_phase_step = PH_VALUE;
                    end
                end else begin
                    w_phase_step = (w_b == CH_CR) ? PH_GOT_CR : PH_SKIP;
                end
            end
            PH_SKIP: begin
                if (w_b == CH_CR) begin
                    w_phase_step = PH_GOT_CR;
                end
            end
            PH_VALUE: begin
                if (w_b == CH_CR) begin
                    w_phase_step = PH_DONE;
                end else if (r_hlen < HL_MAX) begin
                    n_hlen = r_hlen + HL_W'(1);
                end else begin
                    n_hlen = HL_TRUNC;
                end
            end
            default: begin
            end
        endcase
        n_phase = w_phase_step;
        if (w_eob) begin
            n_phase  = PH_FIRST;
            n_recent = '0;
            n_flc    = '0;
            n_kmc    = '0;
            n_hlen   = '0;
        end
    end

    // outputs
    always_comb begin
        w_emit_byte   = 1'b0;
        w_emit_status = 1'b0;
        w_status      = ST_OK;
        unique case (r_phase)
            PH_FIRST: begin
                if (w_b == CH_CR &&
                    !(r_flc >= FLC_MIN && r_recent[63:8] == HTTP_TAG)) begin
                    w_emit_status = 1'b1;
                    w_status      = ST_NOT_HTTP;
                end
            end
            PH_KEYWORD: begin
                if (r_kmc == 3'd0 && w_b == CH_CR) begin
                    w_emit_status = 1'b1;
                    w_status      = ST_NO_HOST;
                end
            end
            PH_VALUE: begin
                if (w_b == CH_CR) begin
                    w_emit_status = 1'b1;
                    w_status      = (r_hlen > HL_MAX) ? ST_TRUNCATED : ST_OK;
                end else if (r_hlen < HL_MAX) begin
                    w_emit_byte = 1'b1;
                end
            end
            default: begin
            end
        endcase
        if (w_eob && !w_emit_status && w_phase_step != PH_DONE) begin
            w_emit_status = 1'b1;
            w_emit_byte   = 1'b0;
            w_status      = ST_EARLY_END;
        end
    end

    always_comb begin
        o_push = w_acc && (w_emit_byte || w_emit_status);
        if (w_emit_status) begin
            o_item.item_kind    = KIND_STATUS;
            o_item.host_byte    = 8'd0;
            o_item.parse_status = w_status;
            o_item.is_final     = 1'b1;
        end else begin
            o_item.item_kind    = KIND_BYTE;
            o_item.host_byte    = w_b;
            o_item.parse_status = ST_OK;
            o_item.is_final     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_FIRST;
            r_recent <= '0;
            r_flc    <= '0;
            r_kmc    <= '0;
            r_hlen   <= '0;
        end else if (w_acc) begin
            r_phase  <= n_phase;
            r_recent <= n_recent;
            r_flc    <= n_flc;
            r_kmc    <= n_kmc;
            r_hlen   <= n_hlen;
        end
    end

endmodule

[rtl/hhx_queue.sv]
`timescale 1ns / 1ps
// Short result queue between the parser and the output stage.
module hhx_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  hhx_pkg::t_out_item i_item,
    output logic               o_space,
    input  logic               i_pop,
    output logic               o_avail,
    output hhx_pkg::t_out_item o_item
);
    import hhx_pkg::*;

    t_out_item           r_mem [QDEPTH];
    logic [QIDX_W-1:0]   r_wr, r_rd;
    logic [QCNT_W-1:0]   r_cnt, n_cnt;

    assign o_space = (r_cnt != QCNT_W'(QDEPTH));
    assign o_avail = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !(i_pop && o_avail)) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push && i_pop && o_avail) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_push) begin
                r_wr <= r_wr + QIDX_W'(1);
            end
            if (i_pop && o_avail) begin
                r_rd <= r_rd + QIDX_W'(1);
            end
        end
    end

endmodule

[rtl/hhx_back.sv]
`timescale 1ns / 1ps
// Back end: output register that hands queued results to the downstream side.
module hhx_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_avail,
    input  hhx_pkg::t_out_item i_item,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_ready,
    output hhx_pkg::t_out_item o_item
);
    import hhx_pkg::*;

    logic      r_valid;
    t_out_item r_item;

    assign o_pop   = i_avail && (!r_valid || i_ready);
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!r_valid || i_ready) begin
            r_valid <= i_avail;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_item <= i_item;
        end
    end

endmodule

[rtl/http_host_header_extractor.sv]
`timescale 1ns / 1ps
// Top level of the HTTP Host header extractor: parser, result queue and output stage.
//
//   channel  | valid        | ready        | request
//   ---------+--------------+--------------+-------------------------------
//   in       | i_in_valid   | o_in_ready   | i_in_item  (payload byte, eob)
//   out      | o_out_valid  | i_out_ready  | o_out_item (host byte/status)
//
// One byte per cycle is accepted while the four-entry result queue has room.
// A result is written into the queue on the edge that accepts its byte, and is
// then loaded into the output register once that register is empty or its
// result is being accepted. Downstream stalls fill the queue, then drop
// o_in_ready. Synchronous reset returns the parser to the first line.
module http_host_header_extractor #(
    parameter int HOST_MAX = 255
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  hhx_pkg::t_in_item  i_in_item,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output hhx_pkg::t_out_item o_out_item
);
    import hhx_pkg::*;

    logic      w_space, w_push, w_avail, w_pop;
    t_out_item w_front_item, w_queue_item;

    hhx_front #(
        .HOST_MAX(HOST_MAX)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .i_space (w_space),
        .o_ready (o_in_ready),
        .i_item  (i_in_item),
        .o_push  (w_push),
        .o_item  (w_front_item)
    );

    hhx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_space (w_space),
        .i_pop   (w_pop),
        .o_avail (w_avail),
        .o_item  (w_queue_item)
    );

    hhx_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (w_avail),
        .i_item  (w_queue_item),
        .o_pop   (w_pop),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (o_out_item)
    );

endmodule
